@@ hdl/qie_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qie_pkg;

	// Commands carried in the input tuser field.
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_PIXEL  = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_OPAQUE = 2'd2;
	localparam logic [1:0] REG_SRGB   = 2'd3;

	// Chunk tags.
	localparam logic [7:0] OP_DIFF = 8'h40;
	localparam logic [7:0] OP_LUMA = 8'h80;
	localparam logic [7:0] OP_RUN  = 8'hC0;
	localparam logic [7:0] OP_RGB  = 8'hFE;
	localparam logic [7:0] OP_RGBA = 8'hFF;

	localparam logic [5:0]  RUN_LIMIT   = 6'd62;
	localparam logic [31:0] BLACK_PIXEL = 32'hFF00_0000;

	// Header and end marker.
	localparam logic [31:0] HDR_MAGIC     = 32'h716F_6966;
	localparam logic [7:0]  CHANNELS_RGB  = 8'd3;
	localparam logic [7:0]  CHANNELS_RGBA = 8'd4;
	localparam logic [7:0]  CS_SRGB       = 8'd0;
	localparam logic [7:0]  CS_LINEAR     = 8'd1;
	localparam logic [7:0]  END_LAST_BYTE = 8'h01;
	localparam logic [3:0]  HDR_LEN       = 4'd14;
	localparam logic [3:0]  END_LEN       = 4'd8;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		DK_HEADER,
		DK_PIXEL,
		DK_FINISH
	} desc_kind_t;

	// One burst of output bytes as the front end describes it.
	typedef struct packed {
		desc_kind_t      kind;
		logic            has_run;
		logic [7:0]      run_byte;
		logic [2:0]      op_len;
		logic [4:0][7:0] op_bytes;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

@@ hdl/qoi_image_encoder_core.sv @@
// QOI image encoder core.
// Input stream: s_axis_tuser carries the command (start, pixel, finish) and
// s_axis_tdata the ARGB pixel. Start emits the 14-byte header and clears the
// encoder state; pixel emits zero to six chunk bytes; finish flushes a pending
// run and emits the 8-byte end marker.
// Output stream: one encoded byte per word on m_axis_tdata; m_axis_tlast marks
// the final byte caused by each input word.
// Configuration: cfg_index selects width, height, the opaque flag or the sRGB
// flag, written with cfg_data on a cfg_valid/cfg_ready handshake; write only
// while idle.
// An item's bytes pass the input stage, the descriptor queue and the output register.
// Throughput: one input word per cycle as long as each produces at most one
// byte and the receiver does not stall; the output side sends one byte per
// cycle while the receiver is ready. A descriptor queue between classification
// and the byte serializer absorbs bursts.
// Reset clears the encoder (opaque black previous pixel, empty run and index
// table) and the configuration. When the receiver stalls, the queue fills and
// then s_axis_tready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module qoi_image_encoder_core #(
	parameter int QUEUE_DEPTH = qie_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // pixel[31:0]
	input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] width_q;
	logic [31:0] height_q;
	logic        force_opaque_q;
	logic        use_srgb_q;

	logic            push;
	logic            pop;
	qie_pkg::desc_t  wr_desc;
	qie_pkg::desc_t  head;
	qie_pkg::qstat_t qstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q        <= '0;
			height_q       <= '0;
			force_opaque_q <= 1'b0;
			use_srgb_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qie_pkg::REG_WIDTH:  width_q        <= cfg_data;
				qie_pkg::REG_HEIGHT: height_q       <= cfg_data;
				qie_pkg::REG_OPAQUE: force_opaque_q <= cfg_data[0];
				qie_pkg::REG_SRGB:   use_srgb_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	qie_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.force_opaque  (force_opaque_q),
		.qstat         (qstat),
		.push          (push),
		.desc          (wr_desc)
	);

	qie_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	qie_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.image_width   (width_q),
		.image_height  (height_q),
		.force_opaque  (force_opaque_q),
		.use_srgb      (use_srgb_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

@@ hdl/qie_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qie_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [31:0]     s_axis_tdata,
	input  wire logic [1:0]      s_axis_tuser,
	input  wire logic            force_opaque,
	input  wire qie_pkg::qstat_t qstat,
	output logic                 push,
	output qie_pkg::desc_t       desc
);

	function automatic logic [5:0] index_hash(input logic [31:0] px);
		logic [5:0] h;
		h = 6'(px[23:16] * 8'd3) + 6'(px[15:8] * 8'd5) + 6'(px[7:0] * 8'd7) +
			6'(px[31:24] * 8'd11);
		return h;
	endfunction

	// Input stage.
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [31:0] px_s1;
	logic [5:0]  slot_s1;
	logic [31:0] idx_rd_s1;
	logic        fwd_s1;
	logic [31:0] fwd_px_s1;
	logic        ent_vld_s1;

	// Encoder state.
	logic [31:0] prev_q;
	logic [5:0]  run_q;
	logic [63:0] idx_vld_q;
	logic [31:0] idx_mem [64];

	logic        accept;
	logic        fire;
	logic [31:0] px_in;
	logic [5:0]  slot_in;

	logic        wr_en;
	logic        clr;
	logic        need_push;
	logic [31:0] prev_d;
	logic [5:0]  run_d;
	logic [31:0] entry;
	logic        hit;
	logic        same;
	logic [5:0]  run_inc;
	logic [7:0]  dr, dg, db, drg, dbg;
	logic [7:0]  d2r, d2g, d2b, lg, lrg, lbg;

	assign fire          = valid_s1 && !qstat.full;
	assign s_axis_tready = !valid_s1 || fire;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign px_in         = force_opaque ? {8'hFF, s_axis_tdata[23:0]} : s_axis_tdata;
	assign slot_in       = index_hash(px_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload of the input stage, with a bypass for a table write made by the
	// item ahead in the same cycle as this item's table read.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= s_axis_tuser;
			px_s1      <= px_in;
			slot_s1    <= slot_in;
			fwd_s1     <= wr_en && (slot_s1 == slot_in);
			fwd_px_s1  <= px_s1;
			ent_vld_s1 <= clr ? 1'b0 :
				((wr_en && (slot_s1 == slot_in)) ? 1'b1 : idx_vld_q[slot_in]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_rd_s1 <= idx_mem[slot_in];
		end
		if (wr_en) begin
			idx_mem[slot_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= qie_pkg::BLACK_PIXEL;
			run_q     <= '0;
			idx_vld_q <= '0;
		end else if (fire) begin
			prev_q <= prev_d;
			run_q  <= run_d;
			if (clr) begin
				idx_vld_q <= '0;
			end else if (wr_en) begin
				idx_vld_q[slot_s1] <= 1'b1;
			end
		end
	end

	// An entry never written since start reads as zero.
	assign entry   = ent_vld_s1 ? (fwd_s1 ? fwd_px_s1 : idx_rd_s1) : '0;
	assign hit     = (entry == px_s1);
	assign same    = (px_s1 == prev_q);
	assign run_inc = run_q + 6'd1;

	assign dr  = px_s1[23:16] - prev_q[23:16];
	assign dg  = px_s1[15:8] - prev_q[15:8];
	assign db  = px_s1[7:0] - prev_q[7:0];
	assign drg = dr - dg;
	assign dbg = db - dg;
	assign d2r = dr + 8'd2;
	assign d2g = dg + 8'd2;
	assign d2b = db + 8'd2;
	assign lg  = dg + 8'd32;
	assign lrg = drg + 8'd8;
	assign lbg = dbg + 8'd8;

	always_comb begin
		desc      = '0;
		need_push = 1'b0;
		wr_en     = 1'b0;
		clr       = 1'b0;
		prev_d    = prev_q;
		run_d     = run_q;
		desc.kind = qie_pkg::DK_PIXEL;
		case (cmd_s1)
			qie_pkg::CMD_START: begin
				need_push = 1'b1;
				desc.kind = qie_pkg::DK_HEADER;
				clr       = 1'b1;
				prev_d    = qie_pkg::BLACK_PIXEL;
				run_d     = '0;
			end
			qie_pkg::CMD_PIXEL: begin
				if (same) begin
					if (run_inc == qie_pkg::RUN_LIMIT) begin
						need_push     = 1'b1;
						desc.has_run  = 1'b1;
						desc.run_byte = qie_pkg::OP_RUN | {2'b00, run_q};
						run_d         = '0;
					end else begin
						run_d = run_inc;
					end
				end else begin
					need_push     = 1'b1;
					desc.has_run  = (run_q != '0);
					desc.run_byte = qie_pkg::OP_RUN | {2'b00, run_q - 6'd1};
					run_d         = '0;
					prev_d        = px_s1;
					if (hit) begin
						desc.op_len      = 3'd1;
						desc.op_bytes[0] = {2'b00, slot_s1};
					end else begin
						wr_en = fire;
						if (px_s1[31:24] != prev_q[31:24]) begin
							desc.op_len      = 3'd5;
							desc.op_bytes[0] = qie_pkg::OP_RGBA;
							desc.op_bytes[1] = px_s1[23:16];
							desc.op_bytes[2] = px_s1[15:8];
							desc.op_bytes[3] = px_s1[7:0];
							desc.op_bytes[4] = px_s1[31:24];
						end else if (d2r[7:2] == '0 && d2g[7:2] == '0 && d2b[7:2] == '0) begin
							desc.op_len      = 3'd1;
							desc.op_bytes[0] = qie_pkg::OP_DIFF |
								{2'b00, d2r[1:0], d2g[1:0], d2b[1:0]};
						end else if (lg[7:6] == '0 && lrg[7:4] == '0 && lbg[7:4] == '0) begin
							desc.op_len      = 3'd2;
							desc.op_bytes[0] = qie_pkg::OP_LUMA | {2'b00, lg[5:0]};
							desc.op_bytes[1] = {lrg[3:0], lbg[3:0]};
						end else begin
							desc.op_len      = 3'd4;
							desc.op_bytes[0] = qie_pkg::OP_RGB;
							desc.op_bytes[1] = px_s1[23:16];
							desc.op_bytes[2] = px_s1[15:8];
							desc.op_bytes[3] = px_s1[7:0];
						end
					end
				end
			end
			qie_pkg::CMD_FINISH: begin
				need_push     = 1'b1;
				desc.kind     = qie_pkg::DK_FINISH;
				desc.has_run  = (run_q != '0);
				desc.run_byte = qie_pkg::OP_RUN | {2'b00, run_q - 6'd1};
				run_d         = '0;
			end
			default: begin
			end
		endcase
	end

	assign push = fire && need_push;

endmodule

`default_nettype wire

@@ hdl/qie_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qie_fifo #(
	parameter int DEPTH = qie_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire qie_pkg::desc_t  wr_desc,
	input  wire logic            pop,
	output qie_pkg::desc_t       head,
	output qie_pkg::qstat_t      qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qie_pkg::desc_t entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head        = entries_q[rd_ptr_q];
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ hdl/qie_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qie_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire qie_pkg::desc_t  head,
	input  wire qie_pkg::qstat_t qstat,
	output logic                 pop,
	input  wire logic [31:0]     image_width,
	input  wire logic [31:0]     image_height,
	input  wire logic            force_opaque,
	input  wire logic            use_srgb,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [7:0]           m_axis_tdata,
	output logic                 m_axis_tlast
);

	logic [3:0] pos_q;
	logic [3:0] body_len;
	logic [3:0] total_len;
	logic [3:0] j;
	logic [7:0] body_byte;
	logic [7:0] cur_byte;
	logic       cur_last;
	logic       load;
	logic       emit;

	assign load = !m_axis_tvalid || m_axis_tready;
	assign emit = load && !qstat.empty;

	always_comb begin
		case (head.kind)
			qie_pkg::DK_HEADER: body_len = qie_pkg::HDR_LEN;
			qie_pkg::DK_FINISH: body_len = qie_pkg::END_LEN;
			default:            body_len = {1'b0, head.op_len};
		endcase
	end

	assign total_len = body_len + {3'b000, head.has_run};
	assign j         = pos_q - {3'b000, head.has_run};
	assign cur_last  = (pos_q == total_len - 4'd1);

	always_comb begin
		body_byte = '0;
		case (head.kind)
			qie_pkg::DK_HEADER: begin
				case (j)
					4'd0:    body_byte = qie_pkg::HDR_MAGIC[31:24];
					4'd1:    body_byte = qie_pkg::HDR_MAGIC[23:16];
					4'd2:    body_byte = qie_pkg::HDR_MAGIC[15:8];
					4'd3:    body_byte = qie_pkg::HDR_MAGIC[7:0];
					4'd4:    body_byte = image_width[31:24];
					4'd5:    body_byte = image_width[23:16];
					4'd6:    body_byte = image_width[15:8];
					4'd7:    body_byte = image_width[7:0];
					4'd8:    body_byte = image_height[31:24];
					4'd9:    body_byte = image_height[23:16];
					4'd10:   body_byte = image_height[15:8];
					4'd11:   body_byte = image_height[7:0];
					4'd12:   body_byte = force_opaque ? qie_pkg::CHANNELS_RGB :
						qie_pkg::CHANNELS_RGBA;
					4'd13:   body_byte = use_srgb ? qie_pkg::CS_SRGB : qie_pkg::CS_LINEAR;
					default: body_byte = '0;
				endcase
			end
			qie_pkg::DK_FINISH: begin
				body_byte = (j == qie_pkg::END_LEN - 4'd1) ? qie_pkg::END_LAST_BYTE : 8'h00;
			end
			default: begin
				body_byte = (j[3] == 1'b0 && j[2:0] < 3'd5) ? head.op_bytes[j[2:0]] : 8'h00;
			end
		endcase
	end

	assign cur_byte = (head.has_run && pos_q == '0) ? head.run_byte : body_byte;
	assign pop      = emit && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (load) begin
			m_axis_tvalid <= !qstat.empty;
			if (emit) begin
				pos_q <= cur_last ? 4'd0 : pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= cur_byte;
			m_axis_tlast <= cur_last;
		end
	end

endmodule

`default_nettype wire

@@ hdl/qie_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qie_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast
);

	// A stalled output word must stay put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// No word is offered while reset is asserted.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// Input back-pressure only comes from a full queue, which implies the
	// serializer has a word on offer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no output pending");

endmodule

bind qoi_image_encoder_core qie_checker u_qie_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/qoi_image_encoder_core_test.sv @@
`timescale 1ns / 1ps

module qoi_image_encoder_core_test;

	// The command code that the encoder has to ignore.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} enc_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // pixel[31:0]
	logic [1:0]  s_axis_tuser;  // command[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // out_byte[7:0]
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// Shadow of the configuration and of the encoder state.
	logic [31:0] img_width;
	logic [31:0] img_height;
	logic        drop_alpha;
	logic        srgb_sel;
	logic [31:0] last_px;
	logic [5:0]  run_count;
	logic [31:0] color_cache[64];

	enc_byte_t   expected_bytes[$];
	int          fail_count;
	bit          stall_on;
	int          src_calm;

	qoi_image_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[qoi_image_encoder_core] ERROR");
		$finish;
	end

	function automatic void clear_encoder();
		last_px = qie_pkg::BLACK_PIXEL;
		run_count = '0;
		foreach (color_cache[i])
			color_cache[i] = '0;
	endfunction

	// Computes the bytes one accepted word produces and queues them.
	function automatic void encode_word(input logic [1:0] cmd, input logic [31:0] word_px);
		logic [7:0]  burst[$];
		logic [31:0] px;
		logic [31:0] prev;
		logic [7:0]  a, r, g, b;
		logic [5:0]  slot;
		byte         dr, dg, db, drg, dbg;
		enc_byte_t   item;
		case (cmd)
		qie_pkg::CMD_START: begin
			for (int k = 3; k >= 0; k--)
				burst.push_back(qie_pkg::HDR_MAGIC[k * 8 +: 8]);
			for (int k = 3; k >= 0; k--)
				burst.push_back(img_width[k * 8 +: 8]);
			for (int k = 3; k >= 0; k--)
				burst.push_back(img_height[k * 8 +: 8]);
			burst.push_back(drop_alpha ? qie_pkg::CHANNELS_RGB : qie_pkg::CHANNELS_RGBA);
			burst.push_back(srgb_sel ? qie_pkg::CS_SRGB : qie_pkg::CS_LINEAR);
			clear_encoder();
		end
		qie_pkg::CMD_PIXEL: begin
			px = word_px;
			if (drop_alpha)
				px[31:24] = 8'hFF;
			if (px == last_px) begin
				run_count++;
				if (run_count == qie_pkg::RUN_LIMIT) begin
					burst.push_back(qie_pkg::OP_RUN | {2'b00, run_count - 6'd1});
					run_count = '0;
				end
			end else begin
				if (run_count != 0)
					burst.push_back(qie_pkg::OP_RUN | {2'b00, run_count - 6'd1});
				run_count = '0;
				prev = last_px;
				last_px = px;
				{a, r, g, b} = px;
				slot = 6'(r * 3 + g * 5 + b * 7 + a * 11);
				if (color_cache[slot] == px) begin
					burst.push_back({2'b00, slot});
				end else begin
					color_cache[slot] = px;
					// Channel deltas wrap modulo 256 and read as signed bytes.
					dr = r - prev[23:16];
					dg = g - prev[15:8];
					db = b - prev[7:0];
					drg = dr - dg;
					dbg = db - dg;
					if (a != prev[31:24]) begin
						burst.push_back(qie_pkg::OP_RGBA);
						burst.push_back(r);
						burst.push_back(g);
						burst.push_back(b);
						burst.push_back(a);
					end else if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 &&
							db >= -2 && db <= 1) begin
						burst.push_back(qie_pkg::OP_DIFF |
							8'(((dr + 2) << 4) | ((dg + 2) << 2) | (db + 2)));
					end else if (dg >= -32 && dg < 32 && drg >= -8 && drg < 8 &&
							dbg >= -8 && dbg < 8) begin
						burst.push_back(qie_pkg::OP_LUMA | 8'(dg + 32));
						burst.push_back(8'(((drg + 8) << 4) | (dbg + 8)));
					end else begin
						burst.push_back(qie_pkg::OP_RGB);
						burst.push_back(r);
						burst.push_back(g);
						burst.push_back(b);
					end
				end
			end
		end
		qie_pkg::CMD_FINISH: begin
			if (run_count != 0)
				burst.push_back(qie_pkg::OP_RUN | {2'b00, run_count - 6'd1});
			run_count = '0;
			// The end marker is seven zero bytes and a closing one.
			repeat (7)
				burst.push_back(8'h00);
			burst.push_back(qie_pkg::END_LAST_BYTE);
		end
		default: begin
		end
		endcase
		foreach (burst[k]) begin
			item.value = burst[k];
			item.last = (k == burst.size() - 1);
			expected_bytes.push_back(item);
		end
	endfunction

	function automatic logic [31:0] offset_pixel(input logic [31:0] base, input int dr,
			input int dg, input int db);
		return {base[31:24], 8'(base[23:16] + dr), 8'(base[15:8] + dg), 8'(base[7:0] + db)};
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [31:0] px);
		int gap;
		if (src_calm > 0) begin
			src_calm--;
		end else if (stall_on && $urandom_range(0, 49) == 0) begin
			src_calm = $urandom_range(15, 40);
		end else if (stall_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		encode_word(cmd, px);
	endtask

	// Holds the input until every pending byte is out. Items that make no byte
	// may still be in flight, so the task keeps waiting once no byte is pending.
	task automatic drain_output();
		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		qie_pkg::REG_WIDTH: img_width = value;
		qie_pkg::REG_HEIGHT: img_height = value;
		qie_pkg::REG_OPAQUE: drop_alpha = value[0];
		qie_pkg::REG_SRGB: srgb_sel = value[0];
		default: begin
		end
		endcase
	endtask

	task automatic configure(input logic [31:0] w, input logic [31:0] h, input logic na,
			input logic srgb);
		drain_output();
		put_reg(qie_pkg::REG_WIDTH, w);
		put_reg(qie_pkg::REG_HEIGHT, h);
		put_reg(qie_pkg::REG_OPAQUE, {31'b0, na});
		put_reg(qie_pkg::REG_SRGB, {31'b0, srgb});
		cfg_valid <= 1'b0;
	endtask

	// Pixels straight out of reset, a run that a differing pixel flushes, the unused command and a finish.
	task automatic test_before_start();
		send_word(qie_pkg::CMD_PIXEL, qie_pkg::BLACK_PIXEL);
		send_word(qie_pkg::CMD_PIXEL, 32'hFF00_0101);
		send_word(CMD_UNUSED, 32'hFFFF_FFFF);
		send_word(qie_pkg::CMD_FINISH, 32'h0000_0000);
	endtask

	task automatic test_header();
		configure(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
		send_word(qie_pkg::CMD_START, 32'h0);
		configure(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
		send_word(qie_pkg::CMD_START, 32'h0);
		// With alpha dropped this becomes an RGB chunk, not RGBA.
		send_word(qie_pkg::CMD_PIXEL, 32'h1234_5678);
	endtask

	task automatic test_chunk_ops();
		logic [31:0] seq[$];
		configure($urandom, $urandom, 1'b0, 1'b0);
		send_word(qie_pkg::CMD_START, 32'h0);
		seq = '{32'hFF00_0101, 32'hFF14_1008, 32'hFF80_6040, 32'h8080_6040, 32'hFF00_0101,
			32'hFFFF_FF00, 32'hFFD7_DFE7, 32'hFFFD_FEFE, 32'h0000_0000, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF};
		foreach (seq[i])
			send_word(qie_pkg::CMD_PIXEL, seq[i]);
		send_word(qie_pkg::CMD_FINISH, 32'h0);
	endtask

	// A pixel stream weighted toward every chunk kind, long runs and other commands mixed in.
	task automatic test_random_stream(input int n_items, input logic na, input logic srgb);
		logic [31:0] w, h, px;
		logic [31:0] palette[$];
		int          sent, reps, pick, dg;
		case ($urandom_range(0, 3))
		0: w = 32'h0;
		1: w = 32'hFFFF_FFFF;
		default: w = $urandom;
		endcase
		h = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
		configure(w, h, na, srgb);
		send_word(qie_pkg::CMD_START, $urandom);
		sent = 1;
		while (sent < n_items) begin
			px = last_px;
			reps = 1;
			pick = $urandom_range(0, 19);
			if (pick < 4) begin
				reps = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 66)
					: $urandom_range(1, 4);
			end else if (pick < 8) begin
				px = offset_pixel(last_px, int'($urandom_range(0, 3)) - 2,
					int'($urandom_range(0, 3)) - 2, int'($urandom_range(0, 3)) - 2);
			end else if (pick < 11) begin
				dg = int'($urandom_range(0, 63)) - 32;
				px = offset_pixel(last_px, dg + int'($urandom_range(0, 15)) - 8, dg,
					dg + int'($urandom_range(0, 15)) - 8);
			end else if (pick < 13 && palette.size() != 0) begin
				px = palette[$urandom_range(0, palette.size() - 1)];
			end else if (pick < 15) begin
				px = offset_pixel(last_px, int'($urandom_range(0, 3)) - 2, 0, 0);
				px[31:24] = 8'($urandom);
			end else if (pick < 18) begin
				px = $urandom;
			end
			if (pick == 18) begin
				send_word(qie_pkg::CMD_FINISH, $urandom);
				sent++;
			end else if (pick == 19) begin
				if ($urandom_range(0, 1) == 0) begin
					send_word(qie_pkg::CMD_START, $urandom);
					sent++;
				end else begin
					send_word(CMD_UNUSED, $urandom);
				end
			end else begin
				repeat (reps) begin
					send_word(qie_pkg::CMD_PIXEL, px);
					sent++;
				end
				palette.push_back(px);
				if (palette.size() > 24)
					void'(palette.pop_front());
			end
		end
		send_word(qie_pkg::CMD_FINISH, $urandom);
	endtask

	initial begin : sink_ready
		int calm;
		int gap;
		calm = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!stall_on || calm > 0) begin
				m_axis_tready <= 1'b1;
				if (calm > 0)
					calm--;
				else if (stall_on && $urandom_range(0, 39) == 0)
					calm = $urandom_range(20, 60);
			end else if ($urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				gap = $urandom_range(1, 5);
				repeat (gap) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("out_byte: expected nothing, actual %02h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_axis_tdata !== want.value) begin
					$error("out_byte: expected %02h, actual %02h", want.value, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_byte: expected %0b, actual %0b", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		src_calm = 0;
		stall_on = 1'b1;
		img_width = '0;
		img_height = '0;
		drop_alpha = 1'b0;
		srgb_sel = 1'b0;
		clear_encoder();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= qie_pkg::CMD_START;
		cfg_valid <= 1'b0;
		cfg_index <= qie_pkg::REG_WIDTH;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_start();
		test_header();
		test_chunk_ops();
		test_random_stream(70, 1'b0, 1'b0);
		test_random_stream(70, 1'b1, 1'b1);
		test_random_stream(70, 1'b0, 1'b1);
		test_random_stream(70, 1'b1, 1'b0);
		stall_on = 1'b0;
		test_random_stream(70, 1'b0, 1'b0);

		drain_output();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("[qoi_image_encoder_core] OK");
		else
			$display("[qoi_image_encoder_core] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/qie_pkg.sv
hdl/qie_front.sv
hdl/qie_fifo.sv
hdl/qie_back.sv
hdl/qoi_image_encoder_core.sv
hdl/qie_checker.sv
test/qoi_image_encoder_core_test.sv
